// ----- hdl/sls_pkg.sv -----
// Shared types and constants for the status LED sequencer.
// No dependencies; every other file in hdl/ depends on this package.
package sls_pkg;

    // Field widths
    localparam int FUNC_W   = 2;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 24;
    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int LED_NUMBER = 2;

    // Event codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_SERVICE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BEAT     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERROR    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_IDENTIFY = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_FLASH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_FLASH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HB_ON       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL   = 3'd6;

    // Configuration reset values
    localparam logic [PERIOD_W-1:0] RST_BEAT_FLASH  = 24'd50000;
    localparam logic [PERIOD_W-1:0] RST_ERROR_FLASH = 24'd100000;
    localparam logic [PERIOD_W-1:0] RST_ID_STEP     = 24'd250000;
    localparam logic [COUNT_W-1:0]  RST_ID_COUNT    = 8'd10;
    localparam logic [PERIOD_W-1:0] RST_HB_PERIOD   = 24'd1000000;
    localparam logic [PERIOD_W-1:0] RST_HB_ON       = 24'd50000;
    localparam logic [LEVEL_W-1:0]  RST_DIM_LEVEL   = 8'd32;

    // Brightness levels
    localparam logic [LEVEL_W-1:0] LVL_OFF    = 8'h00;
    localparam logic [LEVEL_W-1:0] LVL_BRIGHT = 8'hFF;

    // Serial divider request and response
    typedef struct packed {
        logic                start;
        logic [TIME_W-1:0]   dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [TIME_W-1:0]   quotient;
        logic [PERIOD_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ----- hdl/sls_ifs.sv -----
// Valid/ready channel interfaces of the status LED sequencer.
// Depends on sls_pkg for field widths.
interface sls_in_if;
    logic                          valid;
    logic                          ready;
    logic [sls_pkg::FUNC_W-1:0]    func;
    logic [sls_pkg::TIME_W-1:0]    now_time;
    logic                          clock_active;
    logic                          running_defaults;

    modport source (output valid, func, now_time, clock_active, running_defaults,
                    input ready);
    modport sink   (input valid, func, now_time, clock_active, running_defaults,
                    output ready);
endinterface

interface sls_out_if;
    logic                          valid;
    logic                          ready;
    logic                          led_index;
    logic [sls_pkg::LEVEL_W-1:0]   brightness;
    logic [sls_pkg::TIME_W-1:0]    errors_seen;
    logic                          last_of_run;

    modport source (output valid, led_index, brightness, errors_seen, last_of_run,
                    input ready);
    modport sink   (input valid, led_index, brightness, errors_seen, last_of_run,
                    output ready);
endinterface

interface sls_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sls_pkg::CFG_IDX_W-1:0]  index;
    logic [sls_pkg::PERIOD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/sls_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on sls_pkg for widths and the request/response structs.
module sls_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sls_pkg::t_div_req  i_req,
    output sls_pkg::t_div_rsp  o_rsp
);
    import sls_pkg::*;

    localparam int CNT_W = $clog2(TIME_W + 1);

    logic [PERIOD_W-1:0] r_rem;
    logic [TIME_W-1:0]   r_quo;
    logic [PERIOD_W-1:0] r_divisor;
    logic [CNT_W-1:0]    r_left;
    logic                r_busy;
    logic                r_done;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                take;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial = {r_rem, r_quo[TIME_W-1]};
    assign diff  = trial - {1'b0, r_divisor};
    assign take  = trial >= {1'b0, r_divisor};

    // Control: count steps, pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_left <= CNT_W'(TIME_W);
            end else if (r_busy) begin
                r_left <= r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then develop one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= '0;
            r_quo     <= i_req.dividend;
            r_divisor <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            r_quo <= {r_quo[TIME_W-2:0], take};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- hdl/status_led_sequencer_core.sv -----
// Status LED sequencer top level: event intake, service sequencer, result queue.
// Depends on sls_pkg, the channel interfaces in sls_ifs.sv and sls_div.
//
// Beat, error and identify events are taken while idle and produce no result.
// A service tick steps through evaluate and done, with a divide state between
// them when a division is needed: the identify step number and the heartbeat
// phase both go through one shared restoring divider that settles one quotient bit
// a cycle. A service yields zero, one or two LED writes, green first, held in a
// two-entry result register; the next input is taken while these drain, but a
// following service cannot commit its results until the previous ones are
// all transferred. Configuration writes are always ready and take effect at
// once; write them only while the block is idle.
module status_led_sequencer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sls_in_if.sink    i_in,
    sls_out_if.source o_out,
    sls_cfg_if.sink   i_cfg
);
    import sls_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Deadline still pending while (deadline - now) is positive as a signed value
    function automatic logic still_active(input logic [TIME_W-1:0] dl,
                                          input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] d;
        d = dl - now;
        return (d != '0) && !d[TIME_W-1];
    endfunction

    // Configuration registers
    logic [PERIOD_W-1:0] r_beat_flash;
    logic [PERIOD_W-1:0] r_error_flash;
    logic [PERIOD_W-1:0] r_id_step;
    logic [COUNT_W-1:0]  r_id_count;
    logic [PERIOD_W-1:0] r_hb_period;
    logic [PERIOD_W-1:0] r_hb_on;
    logic [LEVEL_W-1:0]  r_dim_level;

    // Event state
    logic [TIME_W-1:0]   r_beat_dl;
    logic [TIME_W-1:0]   r_error_dl;
    logic [TIME_W-1:0]   r_id_dl;
    logic [TIME_W-1:0]   r_id_start;
    logic [TIME_W-1:0]   r_err_cnt;
    logic [LEVEL_W-1:0]  r_shown [LED_NUMBER];

    // Service sequencer
    logic [1:0]          r_state;
    logic [TIME_W-1:0]   r_now;
    logic                r_clk_on;
    logic                r_defaults;
    logic                r_id_act;
    logic                r_beat_act;
    logic                r_err_act;

    // Result queue: one slot per LED, shared counter snapshot
    logic [LED_NUMBER-1:0] r_pend;
    logic [LEVEL_W-1:0]    r_lvl [LED_NUMBER];
    logic [TIME_W-1:0]     r_cnt_snap;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic                in_xfer;
    logic                out_xfer;
    logic [TIME_W-1:0]   id_len;
    logic                n_id_act;
    logic                n_beat_act;
    logic                n_err_act;
    logic                n_need_div;
    logic                id_even_step;
    logic [TIME_W-1:0]   hb_phase;
    logic [LEVEL_W-1:0]  n_green;
    logic [LEVEL_W-1:0]  n_red;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign out_xfer    = o_out.valid && o_out.ready;

    assign id_len = {{(TIME_W-COUNT_W){1'b0}}, r_id_count}
                  * {{(TIME_W-PERIOD_W){1'b0}}, r_id_step};

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat_flash  <= RST_BEAT_FLASH;
            r_error_flash <= RST_ERROR_FLASH;
            r_id_step     <= RST_ID_STEP;
            r_id_count    <= RST_ID_COUNT;
            r_hb_period   <= RST_HB_PERIOD;
            r_hb_on       <= RST_HB_ON;
            r_dim_level   <= RST_DIM_LEVEL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_BEAT_FLASH:  r_beat_flash  <= i_cfg.data;
                REG_ERROR_FLASH: r_error_flash <= i_cfg.data;
                REG_ID_STEP:     r_id_step     <= i_cfg.data;
                REG_ID_COUNT:    r_id_count    <= i_cfg.data[COUNT_W-1:0];
                REG_HB_PERIOD:   r_hb_period   <= i_cfg.data;
                REG_HB_ON:       r_hb_on       <= i_cfg.data;
                REG_DIM_LEVEL:   r_dim_level   <= i_cfg.data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Decide which deadlines are live and whether a division is needed
    always_comb begin
        n_id_act   = still_active(r_id_dl, r_now);
        n_beat_act = still_active(r_beat_dl, r_now);
        n_err_act  = still_active(r_error_dl, r_now);
        div_req.start    = 1'b0;
        div_req.dividend = r_now;
        div_req.divisor  = r_hb_period;
        if (n_id_act) begin
            n_need_div       = (r_id_step != '0);
            div_req.dividend = r_now - r_id_start;
            div_req.divisor  = r_id_step;
        end else begin
            n_need_div = !n_beat_act && !r_clk_on && (r_hb_period != '0);
        end
        div_req.start = (r_state == S_EVAL) && n_need_div;
    end

    sls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Work out both LED levels from the flags and the divider result
    always_comb begin
        id_even_step = !((r_id_step != '0) && div_rsp.quotient[0]);
        hb_phase     = (r_hb_period != '0)
                     ? {{(TIME_W-PERIOD_W){1'b0}}, div_rsp.remainder} : r_now;
        if (r_id_act) begin
            n_green = id_even_step ? LVL_BRIGHT : LVL_OFF;
            n_red   = id_even_step ? LVL_OFF : LVL_BRIGHT;
        end else begin
            priority if (r_beat_act) begin
                n_green = LVL_BRIGHT;
            end else if (r_clk_on) begin
                n_green = LVL_OFF;
            end else begin
                n_green = (hb_phase < {{(TIME_W-PERIOD_W){1'b0}}, r_hb_on})
                        ? r_dim_level : LVL_OFF;
            end
            n_red = (r_defaults || r_err_act) ? LVL_BRIGHT : LVL_OFF;
        end
    end

    // Sequencer and event intake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_beat_dl  <= '0;
            r_error_dl <= '0;
            r_id_dl    <= '0;
            r_id_start <= '0;
            r_err_cnt  <= '0;
            r_shown[0] <= LVL_OFF;
            r_shown[1] <= LVL_OFF;
            r_pend     <= '0;
        end else begin
            // Drop the front result on transfer, green before red
            if (out_xfer) begin
                if (r_pend[0]) begin
                    r_pend[0] <= 1'b0;
                end else begin
                    r_pend[1] <= 1'b0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        unique case (i_in.func)
                            FUNC_BEAT: begin
                                r_beat_dl <= i_in.now_time
                                           + {{(TIME_W-PERIOD_W){1'b0}}, r_beat_flash};
                            end
                            FUNC_ERROR: begin
                                r_err_cnt  <= r_err_cnt + 1'b1;
                                r_error_dl <= i_in.now_time
                                            + {{(TIME_W-PERIOD_W){1'b0}}, r_error_flash};
                            end
                            FUNC_IDENTIFY: begin
                                r_id_start <= i_in.now_time;
                                r_id_dl    <= i_in.now_time + id_len;
                            end
                            FUNC_SERVICE: begin
                                r_state <= S_EVAL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EVAL: begin
                    r_state <= n_need_div ? S_DIV : S_DONE;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Commit only into an empty queue
                    if (r_pend == '0) begin
                        r_pend[0]  <= (n_green != r_shown[0]);
                        r_pend[1]  <= (n_red != r_shown[1]);
                        r_shown[0] <= n_green;
                        r_shown[1] <= n_red;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Latch service inputs and the evaluated deadline flags
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_now      <= i_in.now_time;
            r_clk_on   <= i_in.clock_active;
            r_defaults <= i_in.running_defaults;
        end
        if (r_state == S_EVAL) begin
            r_id_act   <= n_id_act;
            r_beat_act <= n_beat_act;
            r_err_act  <= n_err_act;
        end
        if (r_state == S_DONE && r_pend == '0) begin
            r_lvl[0]   <= n_green;
            r_lvl[1]   <= n_red;
            r_cnt_snap <= r_err_cnt;
        end
    end

    // Present the front of the result queue
    assign o_out.valid       = |r_pend;
    assign o_out.led_index   = !r_pend[0];
    assign o_out.brightness  = r_pend[0] ? r_lvl[0] : r_lvl[1];
    assign o_out.errors_seen = r_cnt_snap;
    assign o_out.last_of_run = !(r_pend[0] && r_pend[1]);

`ifndef NO_ASSERTIONS
    // Divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider done outside the divide state");

    // A queued green write carries the level last shown on green
    a_green_matches_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend[0] |-> (r_lvl[0] == r_shown[0]))
        else $error("queued green level differs from shown level");

    // A service that finds the queue empty commits and returns to idle
    a_done_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_pend == '0) |=> (r_state == S_IDLE))
        else $error("service did not commit into an empty queue");

    // Shown levels move only when a service commits
    a_shown_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> ($stable(r_shown[0]) && $stable(r_shown[1])))
        else $error("shown level changed outside a commit");
`endif

endmodule

// ----- sim/status_led_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for status_led_sequencer_core: directed and random event traffic.
// Depends on sls_pkg, the channel interfaces in hdl/sls_ifs.sv and the core RTL.
module status_led_sequencer_core_tb;
    import sls_pkg::*;

    localparam int SETTLE_CYCLES = 50;
    localparam int MAX_REPORTS   = 100;

    typedef enum int {CFG_SHORT, CFG_WIDE, CFG_MAX, CFG_MIN} t_cfg_profile;

    typedef struct packed {
        logic               led;
        logic [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]  errors;
        logic               last;
    } t_led_write;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sls_in_if  in_ch();
    sls_out_if out_ch();
    sls_cfg_if cfg_ch();

    status_led_sequencer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predicted register file
    logic [TIME_W-1:0]  beat_len_us, err_len_us, id_step_us, id_steps;
    logic [TIME_W-1:0]  hb_period_us, hb_on_us;
    logic [LEVEL_W-1:0] dim_lvl;

    // Predicted sequencer state
    logic [TIME_W-1:0]  beat_due, error_due, id_due, id_origin, error_total;
    logic [LEVEL_W-1:0] lit_level [LED_NUMBER];

    t_led_write led_writes_due[$];
    t_led_write got_write, want_write;
    int         mismatch_count = 0;
    logic [TIME_W-1:0] now_us;
    bit         src_steady, sink_steady;
    int         sink_hold;

    // Free-running clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic bit deadline_open(logic [TIME_W-1:0] due, logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] diff;
        diff = due - t;
        return (diff != '0) && !diff[TIME_W-1];
    endfunction

    // Queue an LED write only when the level changes
    task automatic post_level(bit led, logic [LEVEL_W-1:0] lvl, inout int n);
        t_led_write w;
        if (lit_level[led] != lvl) begin
            lit_level[led] = lvl;
            w.led    = led;
            w.level  = lvl;
            w.errors = error_total;
            w.last   = 1'b0;
            led_writes_due.push_back(w);
            n++;
        end
    endtask

    task automatic predict_led_writes(logic [FUNC_W-1:0] fn, logic [TIME_W-1:0] t,
                                      logic ca, logic rd);
        logic [TIME_W-1:0]  step_no, phase;
        logic [LEVEL_W-1:0] green_lvl, red_lvl;
        int n;
        n = 0;
        case (fn)
            FUNC_BEAT: beat_due = t + beat_len_us;
            FUNC_ERROR: begin
                error_total = error_total + 1;
                error_due   = t + err_len_us;
            end
            FUNC_IDENTIFY: begin
                id_origin = t;
                id_due    = t + id_steps * id_step_us;
            end
            default: begin
                if (deadline_open(id_due, t)) begin
                    // Alternate the LEDs on each identify step; zero step time stays in step 0
                    step_no = '0;
                    if (id_step_us != '0) step_no = (t - id_origin) / id_step_us;
                    green_lvl = step_no[0] ? LVL_OFF : LVL_BRIGHT;
                    red_lvl   = step_no[0] ? LVL_BRIGHT : LVL_OFF;
                end else begin
                    phase = (hb_period_us == '0) ? t : t % hb_period_us;
                    if (deadline_open(beat_due, t)) green_lvl = LVL_BRIGHT;
                    else if (ca)                    green_lvl = LVL_OFF;
                    else green_lvl = (phase < hb_on_us) ? dim_lvl : LVL_OFF;
                    red_lvl = (rd || deadline_open(error_due, t)) ? LVL_BRIGHT : LVL_OFF;
                end
                post_level(1'b0, green_lvl, n);
                post_level(1'b1, red_lvl, n);
                if (n > 0) led_writes_due[led_writes_due.size()-1].last = 1'b1;
            end
        endcase
    endtask

    task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
        case (idx)
            REG_BEAT_FLASH:  beat_len_us    = TIME_W'(val);
            REG_ERROR_FLASH: err_len_us     = TIME_W'(val);
            REG_ID_STEP:     id_step_us     = TIME_W'(val);
            REG_ID_COUNT:    id_steps       = TIME_W'(val[COUNT_W-1:0]);
            REG_HB_PERIOD:   hb_period_us   = TIME_W'(val);
            REG_HB_ON:       hb_on_us       = TIME_W'(val);
            REG_DIM_LEVEL:   dim_lvl        = val[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    // Drive one event and hold it until the transfer
    task automatic send_event(logic [FUNC_W-1:0] fn, logic [TIME_W-1:0] t, logic ca, logic rd);
        int gap;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0) repeat (gap) @(negedge i_clk);
        in_ch.func             = fn;
        in_ch.now_time         = t;
        in_ch.clock_active     = ca;
        in_ch.running_defaults = rd;
        in_ch.valid            = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_led_writes(fn, t, ca, rd);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_results();
        while (led_writes_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain results, then let a service with no result finish before touching registers
    task automatic settle_block();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_profile(t_cfg_profile p);
        logic [PERIOD_W-1:0] period;
        case (p)
            CFG_MAX: begin
                write_reg(REG_BEAT_FLASH, '1);
                write_reg(REG_ERROR_FLASH, '1);
                write_reg(REG_ID_STEP, '1);
                write_reg(REG_ID_COUNT, '1);
                write_reg(REG_HB_PERIOD, '1);
                write_reg(REG_HB_ON, '1);
                write_reg(REG_DIM_LEVEL, '1);
            end
            CFG_MIN: begin
                write_reg(REG_BEAT_FLASH, '0);
                write_reg(REG_ERROR_FLASH, '0);
                write_reg(REG_ID_STEP, 24'd1);
                write_reg(REG_ID_COUNT, '0);
                write_reg(REG_HB_PERIOD, 24'd1);
                write_reg(REG_HB_ON, '0);
                write_reg(REG_DIM_LEVEL, '0);
            end
            CFG_WIDE: begin
                write_reg(REG_BEAT_FLASH, PERIOD_W'($urandom));
                write_reg(REG_ERROR_FLASH, PERIOD_W'($urandom));
                write_reg(REG_ID_STEP, PERIOD_W'($urandom_range(1, 24'hFFFFFF)));
                write_reg(REG_ID_COUNT, PERIOD_W'($urandom));
                write_reg(REG_HB_PERIOD, PERIOD_W'($urandom_range(1, 24'hFFFFFF)));
                write_reg(REG_HB_ON, PERIOD_W'($urandom));
                write_reg(REG_DIM_LEVEL, PERIOD_W'($urandom));
            end
            default: begin
                period = PERIOD_W'($urandom_range(1, 5000));
                write_reg(REG_BEAT_FLASH, PERIOD_W'($urandom_range(0, 4000)));
                write_reg(REG_ERROR_FLASH, PERIOD_W'($urandom_range(0, 6000)));
                write_reg(REG_ID_STEP, PERIOD_W'($urandom_range(1, 1500)));
                write_reg(REG_ID_COUNT, PERIOD_W'($urandom_range(0, 12)));
                write_reg(REG_HB_PERIOD, period);
                write_reg(REG_HB_ON, PERIOD_W'($urandom_range(0, period)));
                write_reg(REG_DIM_LEVEL, PERIOD_W'($urandom));
            end
        endcase
    endtask

    // Advance the event clock: mostly small steps, sometimes a jump anywhere
    function automatic logic [TIME_W-1:0] next_time(int unsigned scale);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return now_us + $urandom_range(0, scale);
        if (r < 80) return now_us + $urandom_range(0, 50);
        if (r < 95) return now_us + $urandom_range(0, scale * 16);
        return $urandom;
    endfunction

    task automatic run_traffic_phase(t_cfg_profile p, int n_items, bit steady);
        int unsigned scale;
        int r;
        logic [FUNC_W-1:0] fn;
        settle_block();
        load_profile(p);
        case (p)
            CFG_MAX:  scale = 4000000;
            CFG_WIDE: scale = 2000000;
            CFG_MIN:  scale = 20;
            default:  scale = 1500;
        endcase
        src_steady  = steady;
        sink_steady = steady;
        for (int i = 0; i < n_items; i++) begin
            // Hold off midway until the block has emptied
            if (i == n_items / 2) wait_results();
            r  = $urandom_range(0, 99);
            fn = (r < 60) ? FUNC_SERVICE : (r < 75) ? FUNC_BEAT :
                 (r < 87) ? FUNC_ERROR : FUNC_IDENTIFY;
            now_us = next_time(scale);
            send_event(fn, now_us, $urandom_range(0, 3) == 0, $urandom_range(0, 4) == 0);
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_power_up_levels();
        send_event(FUNC_SERVICE, 32'd0, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'd60000, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'd60001, 1'b0, 1'b1);
        send_event(FUNC_SERVICE, 32'd60002, 1'b0, 1'b1);
        send_event(FUNC_SERVICE, 32'd70000, 1'b1, 1'b0);
    endtask

    task automatic test_flash_deadlines();
        send_event(FUNC_BEAT, 32'd100000, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'd100001, 1'b1, 1'b0);
        send_event(FUNC_ERROR, 32'd120000, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'd120001, 1'b1, 1'b0);
        send_event(FUNC_SERVICE, 32'd150000, 1'b1, 1'b0);
        send_event(FUNC_SERVICE, 32'd220000, 1'b1, 1'b0);
    endtask

    task automatic test_identify_pattern();
        send_event(FUNC_IDENTIFY, 32'd300000, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'd300000, 1'b1, 1'b0);
        send_event(FUNC_SERVICE, 32'd550000, 1'b1, 1'b0);
        send_event(FUNC_SERVICE, 32'd800000, 1'b0, 1'b1);
        send_event(FUNC_SERVICE, 32'd2800000, 1'b1, 1'b0);
    endtask

    task automatic test_time_wrap();
        send_event(FUNC_BEAT, 32'hFFFF_FFF0, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'h0000_0005, 1'b1, 1'b0);
        send_event(FUNC_ERROR, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_event(FUNC_SERVICE, 32'h8000_0000, 1'b0, 1'b0);
    endtask

    // Zero identify step time and zero heartbeat period
    task automatic test_zero_divisors();
        settle_block();
        write_reg(REG_ID_STEP, '0);
        write_reg(REG_HB_PERIOD, '0);
        write_reg(REG_ID_COUNT, 24'd5);
        write_reg(REG_BEAT_FLASH, '0);
        send_event(FUNC_IDENTIFY, 32'd1000, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'd500, 1'b0, 1'b0);
        send_event(FUNC_BEAT, 32'd0, 1'b0, 1'b0);
        send_event(FUNC_IDENTIFY, 32'd0, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'd64, 1'b0, 1'b0);
        send_event(FUNC_SERVICE, 32'h00FF_0000, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(CFG_SHORT, 120, 1'b0);
        run_traffic_phase(CFG_WIDE, 100, 1'b0);
        run_traffic_phase(CFG_MAX, 80, 1'b0);
        run_traffic_phase(CFG_SHORT, 100, 1'b1);
        run_traffic_phase(CFG_MIN, 60, 1'b0);
        run_traffic_phase(CFG_SHORT, 120, 1'b0);
        run_traffic_phase(CFG_WIDE, 100, 1'b0);
        run_traffic_phase(CFG_SHORT, 150, 1'b0);
    endtask

    // Result side backpressure
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            out_ch.ready = 1'b0;
            sink_hold--;
        end else if (sink_steady) begin
            out_ch.ready = 1'b1;
        end else begin
            sink_hold    = pick_gap();
            out_ch.ready = (sink_hold == 0);
            if (sink_hold > 0) sink_hold--;
        end
    end

    task automatic compare_field(string what, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Check each transfer against the oldest predicted LED write
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_write.led    = out_ch.led_index;
            got_write.level  = out_ch.brightness;
            got_write.errors = out_ch.errors_seen;
            got_write.last   = out_ch.last_of_run;
            if (led_writes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: LED write with none expected, expected none, actual %0h",
                             $time, got_write);
            end else begin
                want_write = led_writes_due.pop_front();
                compare_field("led_index", want_write.led, got_write.led);
                compare_field("brightness", want_write.level, got_write.level);
                compare_field("errors_seen", want_write.errors, got_write.errors);
                compare_field("last_of_run", want_write.last, got_write.last);
            end
        end
    end

    initial begin
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.func             = FUNC_SERVICE;
        in_ch.now_time         = '0;
        in_ch.clock_active     = 1'b0;
        in_ch.running_defaults = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_BEAT_FLASH;
        cfg_ch.data            = '0;
        out_ch.ready           = 1'b0;
        sink_hold              = 0;
        src_steady             = 1'b0;
        sink_steady            = 1'b0;
        now_us                 = '0;
        beat_len_us            = TIME_W'(RST_BEAT_FLASH);
        err_len_us             = TIME_W'(RST_ERROR_FLASH);
        id_step_us             = TIME_W'(RST_ID_STEP);
        id_steps               = TIME_W'(RST_ID_COUNT);
        hb_period_us           = TIME_W'(RST_HB_PERIOD);
        hb_on_us               = TIME_W'(RST_HB_ON);
        dim_lvl                = RST_DIM_LEVEL;
        beat_due               = '0;
        error_due              = '0;
        id_due                 = '0;
        id_origin              = '0;
        error_total            = '0;
        for (int k = 0; k < LED_NUMBER; k++) lit_level[k] = LVL_OFF;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_power_up_levels();
        test_flash_deadlines();
        test_identify_pattern();
        test_time_wrap();
        test_zero_divisors();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
